// ===== rtl/core/alarm_phrase_matcher_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the alarm phrase matcher core
// Shared property wrappers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ALARM_PHRASE_MATCHER_CORE_ASSERT_SVH
`define ALARM_PHRASE_MATCHER_CORE_ASSERT_SVH

// Check a property at every clock edge outside reset
`define APM_ASSERT_ON(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property at every clock edge, reset included
`define APM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/alpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Alarm phrase matcher package
// Window size, phrase table, flag layout and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alpm_pkg;

    // Window of most recent text bytes
    localparam int WINDOW_BYTES = 32;
    localparam int WINDOW_IDX_W = $clog2(WINDOW_BYTES);

    // Phrase table layout
    localparam int PHRASE_COUNT   = 16;
    localparam int PHRASE_IDX_W   = $clog2(PHRASE_COUNT);
    localparam int PHRASE_MAX_LEN = 25;
    localparam int PHRASE_BITS    = 8 * PHRASE_MAX_LEN;

    // Sticky flag layout
    localparam int FLAG_COUNT = 15;
    localparam int OTHER_FLAG = 14;
    localparam int KNOWN_FLAGS = 14;

    localparam logic [31:0] ALARM_OTHER_BIT = 32'h8000_0000;

    // Phrases, right-aligned and zero-padded: the last character sits in
    // the low byte, so byte k matches window position k (newest first).
    localparam logic [PHRASE_BITS-1:0] PHRASE_TEXT [PHRASE_COUNT] = '{
        "Replace battery!",
        "Shutdown imminent!",
        "Fan failure!",
        "No battery installed!",
        "Battery voltage too low!",
        "Battery voltage too high!",
        "Battery charger fail!",
        "Temperature too high!",
        "Internal UPS fault!",
        "Internal failure!",
        "Awaiting power!",
        "Automatic bypass mode!",
        "Manual bypass mode!",
        "Communication fault!",
        "Fuse fault!",
        PHRASE_BITS'({"OTHER_", "ALARMS"})
    };

    // Flag bit set by each phrase
    localparam logic [3:0] PHRASE_FLAG [PHRASE_COUNT] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14
    };

    // Control from the top level to every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Control from the top level to the flag accumulator
    typedef struct packed {
        logic take;
        logic has_byte;
        logic last;
    } acc_ctrl_t;

    // Expected byte of phrase p at window position k; zero means no compare
    function automatic logic [7:0] phrase_byte(
        input logic [PHRASE_IDX_W-1:0] p,
        input logic [WINDOW_IDX_W-1:0] k
    );
        logic [7:0] b;
        b = 8'h00;
        if (int'(k) < PHRASE_MAX_LEN) begin
            b = PHRASE_TEXT[p][8*int'(k) +: 8];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/alarm_phrase_matcher_core.sv =====
// Alarm phrase matcher: takes an alarm text one byte per transaction and,
// on the transaction marked last, returns one 32-bit alarm word with a bit
// for each known phrase seen anywhere in the text (two share bit 8; bit 31 for
// other alarms, or for a non-empty text with no known phrase; zero if empty).
// One transaction is taken every cycle while the result register is free or
// being drained; the word appears in the cycle after the last transaction.
// The rate is set by the row of 32 window cells, which compare the incoming
// byte against all sixteen phrases in the same cycle as it shifts in.
// ----------------------------------------------------------------------------
// Alarm phrase matcher core
// Top level: shift window of byte cells, per-phrase match reduction and the
// flag accumulator with its output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alarm_phrase_matcher_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_alarm_bits
);

    localparam int NCELL = alpm_pkg::WINDOW_BYTES;
    localparam int NPHR  = alpm_pkg::PHRASE_COUNT;

    logic                           take;
    alpm_pkg::cell_ctrl_t           cell_ctrl;
    alpm_pkg::acc_ctrl_t            acc_ctrl;
    logic [7:0]                     cell_in   [NCELL];
    logic [7:0]                     cell_byte [NCELL];
    logic [NPHR-1:0][7:0]           cell_exp  [NCELL];
    logic [NPHR-1:0]                cell_hit  [NCELL];
    logic [NCELL-1:0]               hit_by_phrase [NPHR];
    logic [NPHR-1:0]                phrase_hit;

    // Accept while the result register is free or being drained
    assign s_ready = !m_valid || m_ready;
    assign take    = s_valid && s_ready;

    assign cell_ctrl.shift = take && s_has_byte;
    assign cell_ctrl.clear = take && s_last;

    assign acc_ctrl.take     = take;
    assign acc_ctrl.has_byte = s_has_byte;
    assign acc_ctrl.last     = s_last;

    // Row of window cells, newest byte enters cell 0
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_in[k] = s_text_byte;
        end else begin : g_body
            assign cell_in[k] = cell_byte[k-1];
        end

        for (genvar p = 0; p < NPHR; p++) begin : g_exp
            assign cell_exp[k][p] = alpm_pkg::phrase_byte(
                alpm_pkg::PHRASE_IDX_W'(p), alpm_pkg::WINDOW_IDX_W'(k));
        end

        alpm_window_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .byte_in   (cell_in[k]),
            .exp_bytes (cell_exp[k]),
            .byte_out  (cell_byte[k]),
            .hit       (cell_hit[k])
        );
    end

    // A phrase matches when every cell agrees
    for (genvar p = 0; p < NPHR; p++) begin : g_phrase
        for (genvar k = 0; k < NCELL; k++) begin : g_col
            assign hit_by_phrase[p][k] = cell_hit[k][p];
        end
        assign phrase_hit[p] = &hit_by_phrase[p];
    end

    alpm_alarm_acc u_acc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (acc_ctrl),
        .phrase_hit   (phrase_hit),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_alarm_bits (m_alarm_bits)
    );

endmodule

`default_nettype wire

// ===== rtl/core/alpm_window_cell.sv =====
// ----------------------------------------------------------------------------
// Alarm phrase matcher window cell
// Holds one byte of the text window and compares the byte about to enter
// against every phrase character expected at this position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alpm_window_cell (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire alpm_pkg::cell_ctrl_t                       ctrl,
    input  wire logic [7:0]                                 byte_in,
    input  wire logic [alpm_pkg::PHRASE_COUNT-1:0][7:0]     exp_bytes,
    output logic      [7:0]                                 byte_out,
    output logic      [alpm_pkg::PHRASE_COUNT-1:0]          hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Compare the incoming byte; positions past a phrase's start always pass
    always_comb begin
        for (int p = 0; p < alpm_pkg::PHRASE_COUNT; p++) begin
            hit[p] = (exp_bytes[p] == 8'h00) || (byte_in == exp_bytes[p]);
        end
    end

    // Clear at end of text, else advance on a valid byte
    always_comb begin
        byte_next = byte_reg;
        if (ctrl.clear) begin
            byte_next = 8'h00;
        end else if (ctrl.shift) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/core/alpm_alarm_acc.sv =====
// ----------------------------------------------------------------------------
// Alarm phrase matcher flag accumulator
// Keeps the sticky phrase flags and seen-byte flag, builds the alarm word at
// end of text and holds it in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alpm_alarm_acc (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire alpm_pkg::acc_ctrl_t                ctrl,
    input  wire logic [alpm_pkg::PHRASE_COUNT-1:0]  phrase_hit,
    input  wire logic                               m_ready,
    output logic                                    m_valid,
    output logic      [31:0]                        m_alarm_bits
);

    logic [alpm_pkg::FLAG_COUNT-1:0] found_reg;
    logic [alpm_pkg::FLAG_COUNT-1:0] found_next;
    logic [alpm_pkg::FLAG_COUNT-1:0] found_upd;
    logic [alpm_pkg::FLAG_COUNT-1:0] flag_hit;
    logic                            seen_reg;
    logic                            seen_next;
    logic                            seen_upd;
    logic                            valid_reg;
    logic                            valid_next;
    logic [31:0]                     alarm_reg;
    logic [31:0]                     alarm_next;
    logic [31:0]                     word;

    // Fold phrase hits onto their flag bits
    always_comb begin
        flag_hit = '0;
        for (int p = 0; p < alpm_pkg::PHRASE_COUNT; p++) begin
            if (phrase_hit[p]) begin
                flag_hit[alpm_pkg::PHRASE_FLAG[p]] = 1'b1;
            end
        end
    end

    // Flags including the byte of this transaction
    assign found_upd = (ctrl.has_byte) ? (found_reg | flag_hit) : found_reg;
    assign seen_upd  = seen_reg | ctrl.has_byte;

    // Build the alarm word: other alarms when nothing matched, zero with no byte
    always_comb begin
        word = '0;
        word[alpm_pkg::KNOWN_FLAGS-1:0] = found_upd[alpm_pkg::KNOWN_FLAGS-1:0];
        if (found_upd[alpm_pkg::OTHER_FLAG]) begin
            word = word | alpm_pkg::ALARM_OTHER_BIT;
        end
        if (word == 32'h0000_0000) begin
            word = alpm_pkg::ALARM_OTHER_BIT;
        end
        if (!seen_upd) begin
            word = 32'h0000_0000;
        end
    end

    // Accumulate during the text, clear everything on the final transaction
    always_comb begin
        found_next = found_reg;
        seen_next  = seen_reg;
        if (ctrl.take) begin
            if (ctrl.last) begin
                found_next = '0;
                seen_next  = 1'b0;
            end else begin
                found_next = found_upd;
                seen_next  = seen_upd;
            end
        end
    end

    // Output register: load on final transaction, release when taken
    always_comb begin
        valid_next = valid_reg;
        alarm_next = alarm_reg;
        if (ctrl.take && ctrl.last) begin
            valid_next = 1'b1;
            alarm_next = word;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= '0;
            seen_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
            seen_reg  <= seen_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        alarm_reg <= alarm_next;
    end

    assign m_valid      = valid_reg;
    assign m_alarm_bits = alarm_reg;

endmodule

`default_nettype wire

// ===== rtl/core/alpm_checker.sv =====
// ----------------------------------------------------------------------------
// Alarm phrase matcher checker
// Port-level checks on the result handshake and alarm word layout, bound to the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "alarm_phrase_matcher_core_assert.svh"

module alpm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_last,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_alarm_bits
);

    logic s_take_last;
    logic m_stall;

    assign s_take_last = s_valid && s_ready && s_last;
    assign m_stall     = m_valid && !m_ready;

    // Stalled result holds its word
    `APM_ASSERT_ON(a_result_hold, aclk, aresetn, m_stall |=> (m_valid && $stable(m_alarm_bits)), "result dropped or changed while stalled")

    // Unused bits of the alarm word stay clear
    `APM_ASSERT_ON(a_reserved_zero, aclk, aresetn, m_valid |-> (m_alarm_bits[30:14] == 17'h0), "reserved alarm bits set")

    // Every final transaction yields a result
    `APM_ASSERT_ON(a_last_gives_word, aclk, aresetn, s_take_last |=> m_valid, "final transaction gave no result")

    // No result without a final transaction
    `APM_ASSERT_ON(a_no_spurious, aclk, aresetn, (!s_take_last && !m_stall) |=> !m_valid, "result without final transaction")

    // Reset empties the result register
    `APM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind alarm_phrase_matcher_core alpm_checker u_alpm_checker (.*);

`default_nettype wire

// ===== tb/tb_alarm_phrase_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm phrase matcher core testbench
// Streams alarm texts, one byte per transaction, into the core. Each text is
// built from whole phrases, cut and corrupted phrases, noise and filler.
// Every accepted transaction goes through a local copy of the byte window and
// the sticky alarm flags, and each alarm word is checked against the oldest
// predicted word. Both channels idle at random, with one long output stall.
// ----------------------------------------------------------------------------
module tb_alarm_phrase_matcher_core;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 10;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int RANDOM_ITEMS     = 1100;
    localparam int MIN_WORDS        = 60;
    localparam int REPORT_LIMIT     = 10;
    localparam int PHRASE_TOTAL     = 16;
    localparam int FAN_PHRASE       = 2;
    localparam int WIN_DEPTH        = alpm_pkg::WINDOW_BYTES;
    localparam int OTHER_FLAG_IDX   = 14;
    localparam logic [31:0] OTHER_WORD = 32'h8000_0000;

    // Kinds of segment that make up a random alarm text
    typedef enum int {
        SEG_PHRASE,
        SEG_PREFIX,
        SEG_CORRUPT,
        SEG_NOISE,
        SEG_FILLER
    } segment_kind_e;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_text_byte;
    logic        s_has_byte;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_alarm_bits;

    // Known phrases and the flag bit each one sets
    string alarm_phrases [PHRASE_TOTAL] = '{
        "Replace battery!",
        "Shutdown imminent!",
        "Fan failure!",
        "No battery installed!",
        "Battery voltage too low!",
        "Battery voltage too high!",
        "Battery charger fail!",
        "Temperature too high!",
        "Internal UPS fault!",
        "Internal failure!",
        "Awaiting power!",
        "Automatic bypass mode!",
        "Manual bypass mode!",
        "Communication fault!",
        "Fuse fault!",
        {"OTHER_", "ALARMS"}
    };
    int phrase_flag [PHRASE_TOTAL] = '{
        0, 1, 2, 3, 4, 5, 6, 7, 8, 8, 9, 10, 11, 12, 13, OTHER_FLAG_IDX
    };

    // Predicted matcher state
    logic [7:0]  text_window [WIN_DEPTH];
    logic [14:0] found_alarms;
    logic        byte_seen;
    logic [31:0] expected_words [$];

    int items_sent;
    int words_sent;
    int burst_left;
    bit gaps_on;
    bit hold_off_request;
    int error_count;
    int cycle_count;

    alarm_phrase_matcher_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .s_has_byte   (s_has_byte),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_alarm_bits (m_alarm_bits)
    );

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Clear window, flags and seen-byte marker
    task automatic clear_text_state();
        for (int k = 0; k < WIN_DEPTH; k++) begin
            text_window[k] = 8'h00;
        end
        found_alarms = '0;
        byte_seen    = 1'b0;
    endtask

    // True when phrase p ends at the newest byte of the window
    function automatic logic phrase_ends_window(input int p);
        int         len;
        logic       hit;
        logic [7:0] ch;
        len = alarm_phrases[p].len();
        hit = (len > 0) && (len <= WIN_DEPTH);
        for (int k = 0; k < len && hit; k++) begin
            ch = alarm_phrases[p][len - 1 - k];
            if (text_window[k] != ch) hit = 1'b0;
        end
        return hit;
    endfunction

    // Advance the predicted state by one transaction; queue a word on last
    task automatic predict_alarm_item(input logic [7:0] b, input logic hb, input logic lst);
        logic [31:0] word;
        if (hb) begin
            for (int k = WIN_DEPTH - 1; k > 0; k--) begin
                text_window[k] = text_window[k - 1];
            end
            text_window[0] = b;
            byte_seen = 1'b1;
            for (int p = 0; p < PHRASE_TOTAL; p++) begin
                if (phrase_ends_window(p)) found_alarms[phrase_flag[p]] = 1'b1;
            end
        end
        if (lst) begin
            word = '0;
            if (byte_seen) begin
                word[13:0] = found_alarms[13:0];
                if (found_alarms[OTHER_FLAG_IDX]) word = word | OTHER_WORD;
                if (word == '0) word = OTHER_WORD;
            end
            expected_words.push_back(word);
            clear_text_state();
        end
    endtask

    // Offer one transaction, idling between bursts, and wait for acceptance
    task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on) gap = $urandom_range(0, 8);
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_has_byte  <= hb;
        s_last      <= lst;
        do @(posedge aclk); while (!s_ready);
        predict_alarm_item(b, hb, lst);
        burst_left--;
        items_sent++;
    endtask

    // Build one text from random segments and stream it out
    task automatic send_random_text(input int max_segments);
        logic [7:0]    text_bytes [$];
        segment_kind_e kind;
        int            segs;
        int            r;
        int            p;
        int            len;
        int            cut;
        logic          end_with_byte;
        segs = $urandom_range(0, max_segments);
        for (int s = 0; s < segs; s++) begin
            r    = $urandom_range(0, 9);
            kind = (r < 5) ? SEG_PHRASE : (r < 7) ? SEG_PREFIX :
                   (r == 7) ? SEG_CORRUPT : (r == 8) ? SEG_NOISE : SEG_FILLER;
            p    = $urandom_range(0, PHRASE_TOTAL - 1);
            len  = alarm_phrases[p].len();
            case (kind)
                SEG_PHRASE: begin
                    for (int i = 0; i < len; i++) text_bytes.push_back(alarm_phrases[p][i]);
                end
                SEG_PREFIX: begin
                    cut = $urandom_range(1, len - 1);
                    for (int i = 0; i < cut; i++) text_bytes.push_back(alarm_phrases[p][i]);
                end
                SEG_CORRUPT: begin
                    cut = $urandom_range(0, len - 1);
                    for (int i = 0; i < len; i++) begin
                        if (i == cut) text_bytes.push_back(8'($urandom_range(0, 255)));
                        else text_bytes.push_back(alarm_phrases[p][i]);
                    end
                end
                SEG_NOISE: begin
                    repeat ($urandom_range(1, 6)) text_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    repeat ($urandom_range(1, 4)) text_bytes.push_back(8'($urandom_range(32, 126)));
                end
            endcase
        end

        // Sprinkle empty transactions; end on a byte or on an empty last
        end_with_byte = (text_bytes.size() > 0) && ($urandom_range(0, 2) != 0);
        for (int i = 0; i < text_bytes.size(); i++) begin
            if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(text_bytes[i], 1'b1, end_with_byte && (i == text_bytes.size() - 1));
        end
        if (!end_with_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        words_sent++;
    endtask

    // Empty text, lone bytes, empty transactions and a phrase closed by last
    task automatic test_directed_edges();
        int len;
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        len = alarm_phrases[FAN_PHRASE].len();
        for (int i = 0; i < len; i++) begin
            send_item(alarm_phrases[FAN_PHRASE][i], 1'b1, i == len - 1);
        end
        words_sent += 5;
    endtask

    // Mostly well-formed texts with random content
    task automatic test_random_texts();
        while (items_sent < RANDOM_ITEMS || words_sent < MIN_WORDS) begin
            send_random_text(4);
        end
    endtask

    // Longer texts of up to eight segments, which can run past the window depth
    task automatic test_long_texts();
        repeat (6) send_random_text(8);
    endtask

    // Hold the result side off while short texts keep coming
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_off_request = 1'b1;
        repeat (30) send_random_text(1);
        gaps_on = 1'b1;
    endtask

    // Result side: stretches of differing stall patterns, one long hold-off
    initial begin
        int stall_mode;
        int stretch_len;
        m_ready = 1'b0;
        forever begin
            stall_mode  = $urandom_range(0, 3);
            stretch_len = $urandom_range(10, 80);
            for (int n = 0; n < stretch_len; n++) begin
                @(negedge aclk);
                if (hold_off_request) begin
                    hold_off_request = 1'b0;
                    m_ready <= 1'b0;
                    for (int h = 1; h < HOLD_OFF_CYCLES; h++) @(negedge aclk);
                end else begin
                    case (stall_mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        2:       m_ready <= (n % 4 == 0);
                        default: m_ready <= ($urandom_range(0, 4) != 0);
                    endcase
                end
            end
        end
    end

    // Compare each accepted alarm word with the oldest prediction
    always @(posedge aclk) begin : word_check
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected alarm word %h at cycle %0d", m_alarm_bits, cycle_count);
            end else begin
                want = expected_words.pop_front();
                if (m_alarm_bits !== want) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("alarm word mismatch at cycle %0d: expected %h, got %h",
                                 cycle_count, want, m_alarm_bits);
                end
            end
        end
    end

    // Guard against a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Reset, run the tests in turn, drain and report
    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_text_byte      = 8'h00;
        s_has_byte       = 1'b0;
        s_last           = 1'b0;
        items_sent       = 0;
        words_sent       = 0;
        burst_left       = 0;
        gaps_on          = 1'b1;
        hold_off_request = 1'b0;
        error_count      = 0;
        clear_text_state();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        test_random_texts();
        test_long_texts();
        test_output_backpressure();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
